@@ hw/rtl/mfl_pkg.sv @@
package mfl_pkg;

  localparam int unsigned MFL_MAX_VERTICES = 512;
  localparam int unsigned MFL_MAX_ARCS     = 8192;
  localparam int unsigned MFL_VW           = 9;
  localparam int unsigned MFL_CW           = 10;
  localparam int unsigned MFL_CAP_W        = 30;
  localparam int unsigned MFL_FLOW_W       = 31;

  localparam logic [MFL_CAP_W-1:0]  MFL_FLOW_BOUND = 30'h3f3f3f3f;
  localparam logic [MFL_FLOW_W-1:0] MFL_FLOW_MAX   = 31'h7fffffff;
  localparam logic [MFL_CW-1:0]     MFL_UNREACHED  = 10'h3ff;
  localparam logic [MFL_CW-1:0]     MFL_NV         = 10'(MFL_MAX_VERTICES);
  localparam logic [MFL_CW-1:0]     MFL_LAST_V     = 10'(MFL_MAX_VERTICES - 1);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    OP_IDLE, OP_LATCH, OP_CLR_INIT, OP_CLR,
    OP_ADD_RD, OP_ADD_W0, OP_ADD_W1,
    OP_SW_INIT, OP_SW, OP_SW_END,
    OP_B_INIT, OP_B_POP, OP_B_V, OP_B_HD, OP_B_ARC, OP_B_ARCD, OP_B_CHK,
    OP_SNK_RD, OP_D_INIT, OP_D_TOP, OP_D_CURL, OP_D_POP, OP_D_POPA, OP_D_POPW,
    OP_D_ARC, OP_D_ARCD, OP_D_CHK,
    OP_M_INIT, OP_M_RD, OP_M_A, OP_M_C,
    OP_U_INIT, OP_U_RD, OP_U_A, OP_U_W, OP_U_W2, OP_U_ADD,
    OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    S_BOOT_INIT, S_BOOT, S_IDLE, S_DISPATCH, S_CLR_INIT, S_CLR,
    S_ADD_RD, S_ADD_W0, S_ADD_W1,
    S_SW_INIT, S_SW, S_SW_END,
    S_B_INIT, S_B_POP, S_B_V, S_B_HD, S_B_ARC, S_B_ARCD, S_B_CHK,
    S_SNK_CHK, S_D_TOP, S_D_CURL, S_D_A, S_D_POPA, S_D_POPW, S_D_ARCD, S_D_CHK,
    S_M_RD, S_M_A, S_M_C,
    S_U_RD, S_U_A, S_U_W, S_U_W2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic  sweep_last;
    logic  q_empty;
    logic  arc_none;
    logic  p_zero;
    logic  at_sink;
    logic  i_done;
    logic  bfs_take;
    logic  dfs_take;
    logic  snk_unr;
    logic  req_ok;
    func_t func;
  } mfl_stat_t;

endpackage

@@ hw/rtl/mfl_in_if.sv @@
interface mfl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [8:0] from_vertex;
  logic [8:0] to_vertex;
  logic [29:0] capacity;
  logic [8:0] source_vertex;
  logic [8:0] sink_vertex;

  modport source (output valid, func, from_vertex, to_vertex, capacity, source_vertex,
                  sink_vertex, input ready);
  modport sink (input valid, func, from_vertex, to_vertex, capacity, source_vertex,
                sink_vertex, output ready);
endinterface

@@ hw/rtl/mfl_out_if.sv @@
interface mfl_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] flow_value;
  logic [1:0]  status;

  modport source (output valid, flow_value, status, input ready);
  modport sink (input valid, flow_value, status, output ready);
endinterface

@@ hw/rtl/mfl_dpath.sv @@
module mfl_dpath import mfl_pkg::*; #(
  parameter int unsigned MAX_ARCS = MFL_MAX_ARCS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  op_t         op,
  output mfl_stat_t   st,
  input  logic [1:0]  in_func,
  input  logic [8:0]  in_from,
  input  logic [8:0]  in_to,
  input  logic [29:0] in_cap,
  input  logic [8:0]  in_src,
  input  logic [8:0]  in_snk,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  output logic [30:0] out_flow,
  output logic [1:0]  out_status
);

  localparam int unsigned AW = $clog2(MAX_ARCS);
  localparam logic [AW:0] NO_ARC = (AW+1)'(MAX_ARCS);

  // memories
  logic [MFL_VW-1:0]    tgt_mem [MAX_ARCS];
  logic [MFL_CAP_W-1:0] res_mem [MAX_ARCS];
  logic [AW:0]          nxt_mem [MAX_ARCS];
  logic [AW:0]          head_mem [MFL_MAX_VERTICES];
  logic [AW:0]          cur_mem [MFL_MAX_VERTICES];
  logic [MFL_CW-1:0]    lvl_mem [MFL_MAX_VERTICES];
  logic [MFL_VW-1:0]    que_mem [MFL_MAX_VERTICES];
  logic [AW-1:0]        stk_mem [MFL_MAX_VERTICES];

  logic [MFL_VW-1:0]    tgt_q;
  logic [MFL_CAP_W-1:0] res_q;
  logic [AW:0]          nxt_q, head_q0, head_q1, cur_q;
  logic [MFL_CW-1:0]    lvl_q;
  logic [MFL_VW-1:0]    que_q;
  logic [AW-1:0]        stk_q;

  logic tgt_re, tgt_we, res_re, res_we, nxt_re, nxt_we, head_re, head_we;
  logic cur_re, cur_we, lvl_re, lvl_we, que_re, que_we, stk_re, stk_we;
  logic [AW-1:0] tgt_ra, tgt_wa, res_ra, res_wa, nxt_ra, nxt_wa;
  logic [MFL_VW-1:0] tgt_wd, head_ra0, head_ra1, head_wa, cur_ra, cur_wa;
  logic [MFL_VW-1:0] lvl_ra, lvl_wa, que_ra, que_wa, que_wd, stk_ra, stk_wa;
  logic [MFL_CAP_W-1:0] res_wd;
  logic [AW:0] nxt_wd, head_wd, cur_wd;
  logic [MFL_CW-1:0] lvl_wd;
  logic [AW-1:0] stk_wd;

  // registers
  func_t             func_r;
  status_t           stat_r;
  logic [MFL_VW-1:0] fv_r, tv_r, src_r, snk_r, v_r, sw_r;
  logic [MFL_CAP_W-1:0] cap_r, d_r;
  logic [MFL_CW-1:0] vcnt_r, i_r, qh_r, qt_r, p_r, lv_r;
  logic [AW:0]       arc_cnt_r, a_r;
  logic              sw_v_r, sat_r;
  logic [MFL_FLOW_W-1:0] total_r, out_flow_r;
  status_t           out_stat_r;

  logic [AW+1:0]     cnt_p2;
  logic              req_bad_add, req_bad_run, req_full;
  status_t           req_stat;
  logic [MFL_CW-1:0] pm1;
  logic [AW:0]       a_odd;
  logic [31:0]       sum;
  logic [9:0]        cfg_clamp;

  assign cnt_p2      = {1'b0, arc_cnt_r} + (AW+2)'(2);
  assign req_full    = cnt_p2 > (AW+2)'(MAX_ARCS);
  assign req_bad_add = ({1'b0, in_from} >= vcnt_r) || ({1'b0, in_to} >= vcnt_r);
  assign req_bad_run = ({1'b0, in_src} >= vcnt_r) || ({1'b0, in_snk} >= vcnt_r) ||
                       (in_src == in_snk);
  assign pm1   = p_r - 10'd1;
  assign a_odd = arc_cnt_r | (AW+1)'(1);
  assign sum   = {1'b0, total_r} + {2'b00, d_r};

  always_comb begin
    case (func_t'(in_func))
      FUNC_ADD: req_stat = req_bad_add ? ST_RANGE : (req_full ? ST_FULL : ST_OK);
      FUNC_RUN: req_stat = req_bad_run ? ST_RANGE : ST_OK;
      default:  req_stat = ST_OK;
    endcase
  end

  always_comb begin
    if (cfg_wdata == 10'd0) cfg_clamp = 10'd1;
    else if (cfg_wdata > MFL_NV) cfg_clamp = MFL_NV;
    else cfg_clamp = cfg_wdata;
  end

  always_comb begin
    st.sweep_last = (i_r == MFL_LAST_V);
    st.q_empty    = (qh_r == qt_r);
    st.arc_none   = (a_r >= NO_ARC);
    st.p_zero     = (p_r == '0);
    st.at_sink    = (v_r == snk_r);
    st.i_done     = (i_r == p_r);
    st.bfs_take   = (res_q != '0) && (lvl_q == MFL_UNREACHED) && (qt_r < MFL_NV);
    st.dfs_take   = (res_q != '0) && (lvl_q != MFL_UNREACHED) && (lv_r < lvl_q) &&
                    (p_r < MFL_NV);
    st.snk_unr    = (lvl_q == MFL_UNREACHED);
    st.req_ok     = (stat_r == ST_OK);
    st.func       = func_r;
  end

  // memory port steering
  always_comb begin
    tgt_re = 1'b0; tgt_we = 1'b0; res_re = 1'b0; res_we = 1'b0;
    nxt_re = 1'b0; nxt_we = 1'b0; head_re = 1'b0; head_we = 1'b0;
    cur_re = 1'b0; cur_we = 1'b0; lvl_re = 1'b0; lvl_we = 1'b0;
    que_re = 1'b0; que_we = 1'b0; stk_re = 1'b0; stk_we = 1'b0;
    tgt_ra = a_r[AW-1:0]; res_ra = a_r[AW-1:0]; nxt_ra = a_r[AW-1:0];
    tgt_wa = arc_cnt_r[AW-1:0]; res_wa = arc_cnt_r[AW-1:0]; nxt_wa = arc_cnt_r[AW-1:0];
    tgt_wd = tv_r; res_wd = cap_r; nxt_wd = head_q0;
    head_ra0 = fv_r; head_ra1 = tv_r; head_wa = fv_r; head_wd = arc_cnt_r;
    cur_ra = v_r; cur_wa = v_r; cur_wd = nxt_q;
    lvl_ra = v_r; lvl_wa = sw_r; lvl_wd = MFL_UNREACHED;
    que_ra = qh_r[MFL_VW-1:0]; que_wa = qt_r[MFL_VW-1:0]; que_wd = tgt_q;
    stk_ra = i_r[MFL_VW-1:0]; stk_wa = p_r[MFL_VW-1:0]; stk_wd = a_r[AW-1:0];
    case (op)
      OP_CLR: begin
        head_we = 1'b1; head_wa = i_r[MFL_VW-1:0]; head_wd = NO_ARC;
      end
      OP_ADD_RD: head_re = 1'b1;
      OP_ADD_W0: begin
        tgt_we = 1'b1; res_we = 1'b1; nxt_we = 1'b1; head_we = 1'b1;
      end
      OP_ADD_W1: begin
        tgt_we = 1'b1; res_we = 1'b1; nxt_we = 1'b1; head_we = 1'b1;
        tgt_wa = a_odd[AW-1:0]; res_wa = a_odd[AW-1:0]; nxt_wa = a_odd[AW-1:0];
        tgt_wd = fv_r; res_wd = '0;
        // a self loop finds its forward arc at the head of the same list
        nxt_wd = (fv_r == tv_r) ? arc_cnt_r : head_q1;
        head_wa = tv_r; head_wd = a_odd;
      end
      OP_SW, OP_SW_END: begin
        if (op == OP_SW) begin
          head_re = 1'b1; head_ra0 = i_r[MFL_VW-1:0];
        end
        cur_we = sw_v_r; cur_wa = sw_r; cur_wd = head_q0;
        lvl_we = sw_v_r;
      end
      OP_B_INIT: begin
        lvl_we = 1'b1; lvl_wa = src_r; lvl_wd = '0;
        que_we = 1'b1; que_wa = '0; que_wd = src_r;
      end
      OP_B_POP: que_re = 1'b1;
      OP_B_V: begin
        head_re = 1'b1; head_ra0 = que_q; lvl_re = 1'b1; lvl_ra = que_q;
      end
      OP_B_ARC, OP_D_ARC: begin
        tgt_re = 1'b1; res_re = 1'b1; nxt_re = 1'b1;
      end
      OP_B_ARCD, OP_D_ARCD: begin
        lvl_re = 1'b1; lvl_ra = tgt_q;
      end
      OP_B_CHK: begin
        lvl_we = st.bfs_take; lvl_wa = tgt_q; lvl_wd = lv_r + 10'd1;
        que_we = st.bfs_take;
      end
      OP_SNK_RD: begin
        lvl_re = 1'b1; lvl_ra = snk_r;
      end
      OP_D_TOP: begin
        cur_re = 1'b1; lvl_re = 1'b1;
      end
      OP_D_POP: begin
        stk_re = 1'b1; stk_ra = pm1[MFL_VW-1:0];
      end
      OP_D_POPA: begin
        tgt_re = 1'b1; tgt_ra = stk_q ^ AW'(1);
        nxt_re = 1'b1; nxt_ra = stk_q;
      end
      OP_D_POPW: begin
        cur_we = 1'b1; cur_wa = tgt_q;
      end
      OP_D_CHK: begin
        stk_we = st.dfs_take;
        cur_we = !st.dfs_take;
      end
      OP_M_RD, OP_U_RD: stk_re = 1'b1;
      OP_M_A, OP_U_A: begin
        res_re = 1'b1; res_ra = stk_q;
      end
      OP_U_W: begin
        res_we = 1'b1; res_wa = a_r[AW-1:0]; res_wd = res_q - d_r;
        res_re = 1'b1; res_ra = a_r[AW-1:0] ^ AW'(1);
      end
      OP_U_W2: begin
        res_we = 1'b1; res_wa = a_r[AW-1:0] ^ AW'(1); res_wd = res_q + d_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    if (tgt_re) tgt_q <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    if (res_re) res_q <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (nxt_re) nxt_q <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) begin
      head_q0 <= head_mem[head_ra0];
      head_q1 <= head_mem[head_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (cur_re) cur_q <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    if (lvl_re) lvl_q <= lvl_mem[lvl_ra];
  end

  always_ff @(posedge clk) begin
    if (que_we) que_mem[que_wa] <= que_wd;
    if (que_re) que_q <= que_mem[que_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r    <= MFL_NV;
      arc_cnt_r <= '0;
    end else begin
      if (cfg_we) vcnt_r <= cfg_clamp;
      if (op == OP_CLR_INIT) arc_cnt_r <= '0;
      else if (op == OP_ADD_W1) arc_cnt_r <= arc_cnt_r + (AW+1)'(2);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        func_r  <= func_t'(in_func);
        stat_r  <= req_stat;
        fv_r    <= in_from;
        tv_r    <= in_to;
        cap_r   <= in_cap;
        src_r   <= in_src;
        snk_r   <= in_snk;
        total_r <= '0;
        sat_r   <= 1'b0;
      end
      OP_CLR_INIT, OP_SW_INIT, OP_M_INIT: begin
        i_r    <= '0;
        sw_v_r <= 1'b0;
        d_r    <= MFL_FLOW_BOUND;
      end
      // keep the path minimum found by the scan
      OP_U_INIT: i_r <= '0;
      OP_CLR: i_r <= i_r + 10'd1;
      OP_SW: begin
        sw_r   <= i_r[MFL_VW-1:0];
        sw_v_r <= 1'b1;
        i_r    <= i_r + 10'd1;
      end
      OP_B_INIT: begin
        qh_r <= '0;
        qt_r <= 10'd1;
      end
      OP_B_POP: qh_r <= qh_r + 10'd1;
      OP_B_V: v_r <= que_q;
      OP_B_HD: begin
        a_r  <= head_q0;
        lv_r <= lvl_q;
      end
      OP_B_CHK: begin
        if (st.bfs_take) qt_r <= qt_r + 10'd1;
        a_r <= nxt_q;
      end
      OP_D_INIT: begin
        p_r <= '0;
        v_r <= src_r;
      end
      OP_D_CURL: begin
        a_r  <= cur_q;
        lv_r <= lvl_q;
      end
      OP_D_POP: p_r <= pm1;
      OP_D_POPW: v_r <= tgt_q;
      OP_D_CHK: begin
        if (st.dfs_take) begin
          p_r <= p_r + 10'd1;
          v_r <= tgt_q;
        end else begin
          a_r <= nxt_q;
        end
      end
      OP_M_C: begin
        if (res_q < d_r) d_r <= res_q;
        i_r <= i_r + 10'd1;
      end
      OP_U_A: a_r <= {1'b0, stk_q};
      OP_U_W2: i_r <= i_r + 10'd1;
      OP_U_ADD: begin
        // running total saturates at the top of the 31-bit range
        if (sum[31]) begin
          total_r <= MFL_FLOW_MAX;
          sat_r   <= 1'b1;
        end else begin
          total_r <= sum[30:0];
        end
        p_r <= '0;
        v_r <= src_r;
      end
      OP_OUT: begin
        out_flow_r <= total_r;
        out_stat_r <= sat_r ? ST_SAT : stat_r;
      end
      default: ;
    endcase
  end

  assign out_flow   = out_flow_r;
  assign out_status = out_stat_r;

endmodule

@@ hw/rtl/mfl_ctrl.sv @@
module mfl_ctrl import mfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mfl_stat_t st,
  output op_t       op
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    case (state_r)
      S_BOOT_INIT: begin op = OP_CLR_INIT; state_nxt = S_BOOT; end
      S_BOOT: begin
        op = OP_CLR;
        if (st.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.func)
          FUNC_ADD:   state_nxt = st.req_ok ? S_ADD_RD : S_OUT;
          FUNC_RUN:   state_nxt = st.req_ok ? S_SW_INIT : S_OUT;
          FUNC_CLEAR: state_nxt = S_CLR_INIT;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_CLR_INIT: begin op = OP_CLR_INIT; state_nxt = S_CLR; end
      S_CLR: begin
        op = OP_CLR;
        if (st.sweep_last) state_nxt = S_OUT;
      end
      S_ADD_RD: begin op = OP_ADD_RD; state_nxt = S_ADD_W0; end
      S_ADD_W0: begin op = OP_ADD_W0; state_nxt = S_ADD_W1; end
      S_ADD_W1: begin op = OP_ADD_W1; state_nxt = S_OUT; end
      // new phase: reset levels and load cursors from list heads
      S_SW_INIT: begin op = OP_SW_INIT; state_nxt = S_SW; end
      S_SW: begin
        op = OP_SW;
        if (st.sweep_last) state_nxt = S_SW_END;
      end
      S_SW_END: begin op = OP_SW_END; state_nxt = S_B_INIT; end
      S_B_INIT: begin op = OP_B_INIT; state_nxt = S_B_POP; end
      S_B_POP: begin
        if (st.q_empty) begin
          op = OP_SNK_RD;
          state_nxt = S_SNK_CHK;
        end else begin
          op = OP_B_POP;
          state_nxt = S_B_V;
        end
      end
      S_B_V: begin op = OP_B_V; state_nxt = S_B_HD; end
      S_B_HD: begin op = OP_B_HD; state_nxt = S_B_ARC; end
      S_B_ARC: begin
        if (st.arc_none) state_nxt = S_B_POP;
        else begin
          op = OP_B_ARC;
          state_nxt = S_B_ARCD;
        end
      end
      S_B_ARCD: begin op = OP_B_ARCD; state_nxt = S_B_CHK; end
      S_B_CHK: begin op = OP_B_CHK; state_nxt = S_B_ARC; end
      S_SNK_CHK: begin
        if (st.snk_unr) state_nxt = S_OUT;
        else begin
          op = OP_D_INIT;
          state_nxt = S_D_TOP;
        end
      end
      S_D_TOP: begin
        if (st.at_sink) begin
          op = OP_M_INIT;
          state_nxt = S_M_RD;
        end else begin
          op = OP_D_TOP;
          state_nxt = S_D_CURL;
        end
      end
      S_D_CURL: begin op = OP_D_CURL; state_nxt = S_D_A; end
      S_D_A: begin
        if (st.arc_none) begin
          if (st.p_zero) state_nxt = S_SW_INIT;
          else begin
            op = OP_D_POP;
            state_nxt = S_D_POPA;
          end
        end else begin
          op = OP_D_ARC;
          state_nxt = S_D_ARCD;
        end
      end
      S_D_POPA: begin op = OP_D_POPA; state_nxt = S_D_POPW; end
      S_D_POPW: begin op = OP_D_POPW; state_nxt = S_D_TOP; end
      S_D_ARCD: begin op = OP_D_ARCD; state_nxt = S_D_CHK; end
      S_D_CHK: begin
        op = OP_D_CHK;
        state_nxt = st.dfs_take ? S_D_TOP : S_D_A;
      end
      S_M_RD: begin
        if (st.i_done) begin
          op = OP_U_INIT;
          state_nxt = S_U_RD;
        end else begin
          op = OP_M_RD;
          state_nxt = S_M_A;
        end
      end
      S_M_A: begin op = OP_M_A; state_nxt = S_M_C; end
      S_M_C: begin op = OP_M_C; state_nxt = S_M_RD; end
      S_U_RD: begin
        if (st.i_done) begin
          op = OP_U_ADD;
          state_nxt = S_D_TOP;
        end else begin
          op = OP_U_RD;
          state_nxt = S_U_A;
        end
      end
      S_U_A: begin op = OP_U_A; state_nxt = S_U_W; end
      S_U_W: begin op = OP_U_W; state_nxt = S_U_W2; end
      S_U_W2: begin op = OP_U_W2; state_nxt = S_U_RD; end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          op = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_BOOT_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (op == OP_OUT) out_valid_nxt = 1'b1;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_out_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_OUT) |=> out_valid_r)
    else $error("result beat not presented after load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> (op != OP_OUT))
    else $error("pending result overwritten");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted beat not dispatched");

  a_dfs_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_CHK && st.dfs_take) |=> (state_r == S_D_TOP))
    else $error("path step lost");

endmodule

@@ hw/rtl/max_flow_level_graph_top.sv @@
// Dinic max-flow engine. A valid add-edge beat writes a forward and reverse
// arc, a clear beat runs a pass over the list heads, and after reset such a
// pass runs before the first beat is taken. A run beat is data dependent:
// each phase runs a pass that resets levels and loads cursors, a level search
// over the reached vertices and their arcs, a depth-first search that
// advances, retreats and skips arcs, and an update of the arcs of each
// augmenting path, all stepped by the controller through the arc and vertex
// memories. One item is worked on at a time; a finished result waits in the
// output register while the next beat is accepted.
module max_flow_level_graph_top import mfl_pkg::*; #(
  parameter int unsigned MAX_ARCS = MFL_MAX_ARCS
) (
  input  logic       clk,
  input  logic       rst_n,
  mfl_in_if.sink     in_ch,
  mfl_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  op_t       op;
  mfl_stat_t st;

  mfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .op        (op)
  );

  mfl_dpath #(.MAX_ARCS(MAX_ARCS)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .st         (st),
    .in_func    (in_ch.func),
    .in_from    (in_ch.from_vertex),
    .in_to      (in_ch.to_vertex),
    .in_cap     (in_ch.capacity),
    .in_src     (in_ch.source_vertex),
    .in_snk     (in_ch.sink_vertex),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_flow   (out_ch.flow_value),
    .out_status (out_ch.status)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mfl_pkg::*;

  typedef struct {
    func_t     func;
    bit [8:0]  from_v;
    bit [8:0]  to_v;
    bit [29:0] cap;
    bit [8:0]  src;
    bit [8:0]  snk;
  } flow_cmd_t;

  typedef struct {
    bit [30:0] flow;
    status_t   status;
  } flow_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  mfl_in_if  in_ch ();
  mfl_out_if out_ch ();

  max_flow_level_graph_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // mirror of the residual graph
  bit [8:0]  arc_to   [MFL_MAX_ARCS];
  bit [29:0] arc_res  [MFL_MAX_ARCS];
  bit [13:0] arc_link [MFL_MAX_ARCS];
  bit [13:0] head_of  [MFL_MAX_VERTICES];
  bit [9:0]  level_of [MFL_MAX_VERTICES];
  bit [13:0] cursor_of[MFL_MAX_VERTICES];
  bit [8:0]  bfs_fifo [MFL_MAX_VERTICES];
  bit [12:0] path_arc [MFL_MAX_VERTICES];
  int unsigned n_arcs;
  int unsigned n_vert;

  flow_res_t flow_q[$];
  int errors = 0;
  int in_idle = 0;
  int out_stall = 0;

  function automatic void wipe_graph();
    for (int i = 0; i < MFL_MAX_VERTICES; i++) head_of[i] = 14'(MFL_MAX_ARCS);
    n_arcs = 0;
  endfunction

  function automatic void label_from(int unsigned s);
    int unsigned qh, qt, v, a, w;
    qh = 0;
    qt = 0;
    for (int i = 0; i < MFL_MAX_VERTICES; i++) level_of[i] = MFL_UNREACHED;
    level_of[s] = 0;
    bfs_fifo[qt++] = 9'(s);
    while (qh < qt) begin
      v = bfs_fifo[qh++];
      for (a = head_of[v]; a < MFL_MAX_ARCS; a = arc_link[a]) begin
        w = arc_to[a];
        if (arc_res[a] > 0 && level_of[w] == MFL_UNREACHED && qt < MFL_MAX_VERTICES) begin
          level_of[w] = level_of[v] + 10'd1;
          bfs_fifo[qt++] = 9'(w);
        end
      end
    end
  endfunction

  function automatic int unsigned push_path(int unsigned s, int unsigned t);
    int unsigned p, v, a, w, d;
    p = 0;
    v = s;
    while (1) begin
      if (v == t) begin
        d = MFL_FLOW_BOUND;
        for (int i = 0; i < p; i++)
          if (arc_res[path_arc[i]] < d) d = arc_res[path_arc[i]];
        for (int i = 0; i < p; i++) begin
          arc_res[path_arc[i]] = arc_res[path_arc[i]] - 30'(d);
          arc_res[path_arc[i] ^ 13'd1] = arc_res[path_arc[i] ^ 13'd1] + 30'(d);
        end
        return d;
      end
      a = cursor_of[v];
      if (a >= MFL_MAX_ARCS) begin
        if (p == 0) return 0;
        p--;
        a = path_arc[p];
        v = arc_to[a ^ 1];
        cursor_of[v] = arc_link[a];
      end else begin
        w = arc_to[a];
        if (arc_res[a] > 0 && level_of[w] != MFL_UNREACHED && level_of[v] < level_of[w] &&
            p < MFL_MAX_VERTICES) begin
          path_arc[p++] = 13'(a);
          v = w;
        end else begin
          cursor_of[v] = arc_link[a];
        end
      end
    end
    return 0;
  endfunction

  function automatic longint unsigned total_flow(int unsigned s, int unsigned t);
    longint unsigned total;
    int unsigned d;
    total = 0;
    while (1) begin
      label_from(s);
      if (level_of[t] == MFL_UNREACHED) return total;
      for (int i = 0; i < MFL_MAX_VERTICES; i++) cursor_of[i] = head_of[i];
      d = push_path(s, t);
      while (d > 0) begin
        total += d;
        d = push_path(s, t);
      end
    end
    return total;
  endfunction

  function automatic flow_res_t apply_cmd(flow_cmd_t c);
    flow_res_t r;
    longint unsigned f;
    int unsigned a;
    r.flow = '0;
    r.status = ST_OK;
    case (c.func)
      FUNC_ADD: begin
        if (c.from_v >= n_vert || c.to_v >= n_vert) begin
          r.status = ST_RANGE;
        end else if (n_arcs + 2 > MFL_MAX_ARCS) begin
          r.status = ST_FULL;
        end else begin
          a = n_arcs;
          arc_to[a] = c.to_v;
          arc_res[a] = c.cap;
          arc_link[a] = head_of[c.from_v];
          head_of[c.from_v] = 14'(a);
          arc_to[a+1] = c.from_v;
          arc_res[a+1] = '0;
          arc_link[a+1] = head_of[c.to_v];
          head_of[c.to_v] = 14'(a + 1);
          n_arcs = a + 2;
        end
      end
      FUNC_RUN: begin
        if (c.src >= n_vert || c.snk >= n_vert || c.src == c.snk) begin
          r.status = ST_RANGE;
        end else begin
          f = total_flow(c.src, c.snk);
          if (f > MFL_FLOW_MAX) begin
            r.flow = MFL_FLOW_MAX;
            r.status = ST_SAT;
          end else begin
            r.flow = 31'(f);
          end
        end
      end
      FUNC_CLEAR: wipe_graph();
      default: ;
    endcase
    return r;
  endfunction

  function automatic flow_cmd_t make_cmd(func_t f, int fv, int tv, bit [29:0] cap,
                                         int sv, int kv);
    flow_cmd_t c;
    c.func = f;
    c.from_v = 9'(fv);
    c.to_v = 9'(tv);
    c.cap = cap;
    c.src = 9'(sv);
    c.snk = 9'(kv);
    return c;
  endfunction

  task automatic send(flow_cmd_t c);
    int gap;
    flow_res_t exp_r;
    gap = ($urandom_range(99) < in_idle) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= c.func;
    in_ch.from_vertex <= c.from_v;
    in_ch.to_vertex <= c.to_v;
    in_ch.capacity <= c.cap;
    in_ch.source_vertex <= c.src;
    in_ch.sink_vertex <= c.snk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_r = apply_cmd(c);
    flow_q = {flow_q, exp_r};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (flow_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_vertex_count(bit [9:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_vert = (v < 1) ? 1 : (v > MFL_MAX_VERTICES) ? MFL_MAX_VERTICES : v;
  endtask

  // result beat checker and receiver stalls
  always @(posedge clk) begin
    flow_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (flow_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: flow %0d status %0d",
                                   out_ch.flow_value, out_ch.status);
      end else begin
        want = flow_q.pop_front();
        if (out_ch.flow_value !== want.flow || out_ch.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: flow exp %0d got %0d, status exp %0d got %0d",
                     want.flow, out_ch.flow_value, want.status, out_ch.status);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_stall);
  end

  function automatic bit [29:0] pick_cap();
    case ($urandom_range(7))
      0, 1: return 30'($urandom);
      2: return MFL_FLOW_BOUND;
      3: return 30'h3fffffff;
      4: return '0;
      default: return 30'($urandom_range(1, 100));
    endcase
  endfunction

  task automatic test_limits();
    set_vertex_count(10'd512);
    send(make_cmd(FUNC_ADD, 0, 511, 30'h3fffffff, 0, 0));
    send(make_cmd(FUNC_ADD, 511, 0, '0, 0, 0));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 0, 511));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 511, 0));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 7, 7));
    send(make_cmd(FUNC_NONE, 511, 511, 30'h3fffffff, 511, 511));
    send(make_cmd(FUNC_CLEAR, 0, 0, '0, 0, 0));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 0, 511));
    set_vertex_count(10'd4);
    send(make_cmd(FUNC_ADD, 0, 4, 30'd5, 0, 0));
    send(make_cmd(FUNC_ADD, 4, 0, 30'd5, 0, 0));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 0, 5));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 5, 0));
    send(make_cmd(FUNC_ADD, 0, 1, 30'd5, 0, 0));
    send(make_cmd(FUNC_ADD, 1, 3, 30'd3, 0, 0));
    send(make_cmd(FUNC_ADD, 0, 2, 30'd4, 0, 0));
    send(make_cmd(FUNC_ADD, 2, 3, 30'd6, 0, 0));
    send(make_cmd(FUNC_ADD, 1, 2, 30'd2, 0, 0));
    send(make_cmd(FUNC_ADD, 2, 2, 30'd9, 0, 0));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 0, 3));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 0, 3));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 3, 0));
  endtask

  task automatic test_saturation();
    set_vertex_count(10'd2);
    send(make_cmd(FUNC_CLEAR, 0, 0, '0, 0, 0));
    repeat (3) send(make_cmd(FUNC_ADD, 0, 1, 30'h3fffffff, 0, 0));
    send(make_cmd(FUNC_RUN, 0, 0, '0, 0, 1));
  endtask

  task automatic test_random();
    bit [9:0] counts[6] = '{10'd16, 10'd0, 10'd1023, 10'd5, 10'd40, 10'd12};
    int sent;
    int r;
    int k;
    for (int ph = 0; ph < 6; ph++) begin
      set_vertex_count(counts[ph]);
      case (ph % 4)
        0: begin in_idle = 0;  out_stall = 0;  end
        1: begin in_idle = 66; out_stall = 0;  end
        2: begin in_idle = 0;  out_stall = 66; end
        default: begin in_idle = 7; out_stall = 7; end
      endcase
      sent = 0;
      while (sent < 290) begin
        r = $urandom_range(99);
        if (r < 5) begin
          send(make_cmd(FUNC_CLEAR, $urandom, $urandom, 30'($urandom), $urandom, $urandom));
          sent++;
        end else if (r < 8) begin
          send(make_cmd(FUNC_NONE, $urandom, $urandom, 30'($urandom), $urandom, $urandom));
          sent++;
        end else if (r < 16) begin
          // noise: ends anywhere in the field range
          if ($urandom_range(1))
            send(make_cmd(FUNC_RUN, $urandom, $urandom, 30'($urandom), $urandom, $urandom));
          else
            send(make_cmd(FUNC_ADD, $urandom, $urandom, pick_cap(), $urandom, $urandom));
          sent++;
        end else begin
          k = $urandom_range(3, 12);
          repeat (k) begin
            send(make_cmd(FUNC_ADD, $urandom_range(0, n_vert - 1),
                          $urandom_range(0, n_vert - 1), pick_cap(), $urandom, $urandom));
            sent++;
          end
          send(make_cmd(FUNC_RUN, $urandom, $urandom, 30'($urandom),
                        $urandom_range(0, n_vert - 1), $urandom_range(0, n_vert - 1)));
          sent++;
        end
      end
    end
    in_idle = 0;
    out_stall = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ADD;
    in_ch.from_vertex = '0;
    in_ch.to_vertex = '0;
    in_ch.capacity = '0;
    in_ch.source_vertex = '0;
    in_ch.sink_vertex = '0;
    n_vert = MFL_MAX_VERTICES;
    wipe_graph();
    for (int i = 0; i < MFL_MAX_VERTICES; i++) level_of[i] = MFL_UNREACHED;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_limits();
    test_saturation();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
